/* src/ssfl_pkg.sv */
// ----------------------------------------------------------------------------
// Substring search package
// Shared types, sizes and the case folding function of the substring search.
// ----------------------------------------------------------------------------
package ssfl_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int OFFSET_BITS = 16;
    localparam int LEN_BITS    = $clog2(PATTERN_MAX + 1);
    localparam int IDX_BITS    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT = {OFFSET_BITS{1'b1}};

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CASELESS  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIND_LAST = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef struct packed {
        logic step;
        logic load;
        logic clr;
    } t_cell_ctl;

    function automatic logic [7:0] fold_byte(input logic caseless, input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (caseless && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

/* src/ssfl_cell.sv */
// ----------------------------------------------------------------------------
// Substring search cell
// Holds one pattern byte and its partial match flag, extended from the
// neighbor's flag on every text beat that steps this cell.
// ----------------------------------------------------------------------------
module ssfl_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssfl_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_caseless,
    input  logic [7:0]           i_text,
    input  logic [7:0]           i_wr_byte,
    input  logic                 i_prev,
    output logic                 o_hit,
    output logic                 o_bit
);
    import ssfl_pkg::*;

    logic [7:0] r_pat;
    logic       r_bit;
    logic       n_bit;

    assign o_hit = i_prev && (fold_byte(i_caseless, r_pat) == i_text);
    assign o_bit = r_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.clr || i_ctl.load) begin
            n_bit = 1'b0;
        end else if (i_ctl.step) begin
            n_bit = o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pat <= i_wr_byte;
        end
    end

endmodule

/* src/substring_search_first_last.sv */
// Result: registered on its end-of-text beat and shown on the output in the next cycle.
// Throughput: one beat of any op per cycle unless o_stall holds the input; the cell
// row compares every pattern position against the text byte in parallel, and the
// stall input holds the single output register.
// Reset: synchronous, active low; clears the pattern length, match flags, counters
// and configuration. Pattern bytes are not cleared.
// ----------------------------------------------------------------------------
// Substring search, first or last match
// Streams text bytes through a row of pattern cells and reports the first or
// last match offset at end of text.
// ----------------------------------------------------------------------------
module substring_search_first_last (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_op,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_found,
    output logic [ssfl_pkg::OFFSET_BITS-1:0]   o_match_offset,
    output logic                               o_pattern_overflow,
    output logic                               o_text_overflow,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssfl_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic                               i_cfg_data
);
    import ssfl_pkg::*;

    logic                   r_caseless;
    logic                   r_find_last;
    logic [LEN_BITS-1:0]    r_len;
    logic [LEN_BITS-1:0]    n_len;
    logic                   r_dropped;
    logic                   n_dropped;
    logic [OFFSET_BITS-1:0] r_count;
    logic [OFFSET_BITS-1:0] n_count;
    logic                   r_sat;
    logic                   n_sat;
    logic                   r_have;
    logic                   n_have;
    logic [OFFSET_BITS-1:0] r_best;
    logic [OFFSET_BITS-1:0] n_best;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   r_found;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_pov;
    logic                   r_tov;

    t_op                    w_op;
    logic                   w_accept;
    logic                   w_step;
    logic                   w_full;
    logic                   w_hit;
    logic                   w_end;
    logic [7:0]             w_text;
    logic [IDX_BITS-1:0]    w_last_idx;
    logic [OFFSET_BITS-1:0] w_start;
    logic                   w_res_found;
    logic [OFFSET_BITS-1:0] w_res_offset;
    logic [PATTERN_MAX-1:0] w_hits;
    logic [PATTERN_MAX-1:0] w_bits;

    assign o_stall     = r_out_valid && i_stall;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !o_stall;
    assign w_op        = t_op'(i_op);
    assign w_full      = (r_len == LEN_BITS'(PATTERN_MAX));
    assign w_step      = w_accept && (w_op == OP_TEXT) && (r_count != OFFSET_LIMIT);
    assign w_end       = w_accept && (w_op == OP_END);
    assign w_text      = fold_byte(r_caseless, i_data_byte);
    assign w_last_idx  = IDX_BITS'(r_len - LEN_BITS'(1));
    assign w_hit       = w_step && (r_len != '0) && w_hits[w_last_idx];
    assign w_start     = r_count + OFFSET_BITS'(1) - OFFSET_BITS'(r_len);

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        t_cell_ctl w_ctl;
        logic      w_prev;

        assign w_ctl.step = w_step && (LEN_BITS'(k) < r_len);
        assign w_ctl.load = w_accept && (w_op == OP_APPEND) && !w_full
                            && (r_len == LEN_BITS'(k));
        assign w_ctl.clr  = w_accept && ((w_op == OP_CLEAR) || (w_op == OP_END));

        if (k == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_bits[k-1];
        end

        ssfl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_caseless (r_caseless),
            .i_text     (w_text),
            .i_wr_byte  (i_data_byte),
            .i_prev     (w_prev),
            .o_hit      (w_hits[k]),
            .o_bit      (w_bits[k])
        );
    end

    always_comb begin
        if (r_len == '0) begin
            w_res_found  = 1'b1;
            w_res_offset = r_find_last ? r_count : '0;
        end else begin
            w_res_found  = r_have;
            w_res_offset = r_have ? r_best : '0;
        end
    end

    always_comb begin
        n_len     = r_len;
        n_dropped = r_dropped;
        n_count   = r_count;
        n_sat     = r_sat;
        n_have    = r_have;
        n_best    = r_best;
        if (w_accept) begin
            case (w_op)
                OP_CLEAR: begin
                    n_len     = '0;
                    n_dropped = 1'b0;
                end
                OP_APPEND: begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_len = r_len + LEN_BITS'(1);
                    end
                end
                OP_TEXT: begin
                    if (r_count == OFFSET_LIMIT) begin
                        n_sat = 1'b1;
                    end else begin
                        n_count = r_count + OFFSET_BITS'(1);
                        if (w_hit) begin
                            n_have = 1'b1;
                            if (r_find_last || !r_have) begin
                                n_best = w_start;
                            end
                        end
                    end
                end
                default: begin
                    n_count = '0;
                    n_sat   = 1'b0;
                    n_have  = 1'b0;
                    n_best  = '0;
                end
            endcase
        end
    end

    always_comb begin
        if (w_end) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caseless  <= 1'b0;
            r_find_last <= 1'b0;
            r_len       <= '0;
            r_dropped   <= 1'b0;
            r_count     <= '0;
            r_sat       <= 1'b0;
            r_have      <= 1'b0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CASELESS:  r_caseless  <= i_cfg_data;
                    CFG_FIND_LAST: r_find_last <= i_cfg_data;
                endcase
            end
            r_len       <= n_len;
            r_dropped   <= n_dropped;
            r_count     <= n_count;
            r_sat       <= n_sat;
            r_have      <= n_have;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_found  <= w_res_found;
            r_offset <= w_res_offset;
            r_pov    <= r_dropped;
            r_tov    <= r_sat;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_found            = r_found;
    assign o_match_offset     = r_offset;
    assign o_pattern_overflow = r_pov;
    assign o_text_overflow    = r_tov;

endmodule
